@@ rtl/fca_pkg.sv @@
// Package for the first-fit coalescing allocator.
// Holds field widths, default sizes and the request mode codes.
// No dependencies.
`default_nettype none

package fca_pkg;

  localparam int AddrW     = 12;
  localparam int ReqW      = 15;
  localparam int CfgW      = 13;
  localparam int ModeW     = 2;
  localparam int InDataW   = 32;
  localparam int OutDataW  = 16;

  localparam int UnitBytes    = 8;
  localparam int PoolUnitsDef = 4096;

  localparam logic [CfgW-1:0] CfgReset = 13'd4096;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

endpackage

`default_nettype wire

@@ rtl/first_fit_coalescing_allocator_top.sv @@
// Top level of the first-fit coalescing allocator: sequencer, header store, result register.
// Depends on fca_pkg.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser: mode; tdata: request_bytes, block_addr
//   m_axis    out  m_axis_tvalid / m_axis_tready  tuser: granted; tdata: result_addr
//   cfg       in   cfg_we_i                       cfg_wdata_i: pool_units
//
// Init, no-op and null-free requests go straight from idle to the result state.
// Allocate reads free-list entries in turn until one is large enough or the list runs out;
// free walks the list to the entry before the freed block and then merges with its neighbours.
// The header store needs no clearing pass; the block is ready right after reset.
// A new request is taken while the previous result waits in the output register.
`default_nettype none

module first_fit_coalescing_allocator_top #(
  parameter int POOL_UNITS = fca_pkg::PoolUnitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [fca_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [14:0] request_bytes, [26:15] block_addr, [31:27] zero
  input  wire [fca_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] mode
  input  wire [fca_pkg::ModeW-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [11:0] result_addr, [15:12] zero
  output logic [fca_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] granted
  output logic [0:0]                   m_axis_tuser
);

  import fca_pkg::*;

  localparam int AW = $clog2(POOL_UNITS);
  localparam int LW = AW + 1;
  localparam int CW = ((LW > 16) ? LW : 16) + 1;
  localparam int SW = LW + 1;
  localparam int HW = 2 * LW;

  localparam logic [LW-1:0] Nil     = LW'(POOL_UNITS);
  localparam logic [CW-1:0] PoolC   = CW'(POOL_UNITS);
  localparam logic [SW-1:0] PoolS   = SW'(POOL_UNITS);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_A_RD  = 15'b000000000000010,
    S_A_EV  = 15'b000000000000100,
    S_A_WN  = 15'b000000000001000,
    S_A_WB  = 15'b000000000010000,
    S_A_WP  = 15'b000000000100000,
    S_F_CHK = 15'b000000001000000,
    S_F_EV  = 15'b000000010000000,
    S_F_RDP = 15'b000000100000000,
    S_F_EVP = 15'b000001000000000,
    S_F_RDQ = 15'b000010000000000,
    S_F_EVQ = 15'b000100000000000,
    S_F_WP  = 15'b001000000000000,
    S_F_WB  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [LW-1:0]     head_q, head_d;
  logic [CfgW-1:0]   pool_q;
  logic [SW-1:0]     steps_q, steps_d;
  logic              m_valid_q, m_valid_d;

  logic [CW-1:0]     need_q, need_d;
  logic [LW-1:0]     p_q, p_d;
  logic [LW-1:0]     q_q, q_d;
  logic [AW-1:0]     b_q, b_d;
  logic              bh_q, bh_d;
  logic [LW-1:0]     b_size_q, b_size_d;
  logic [LW-1:0]     cur_link_q, cur_link_d;
  logic [LW-1:0]     cur_size_q, cur_size_d;
  logic [LW-1:0]     new_link_q, new_link_d;
  logic              split_q, split_d;
  logic              res_ok_q, res_ok_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic              m_granted_q, m_granted_d;
  logic [AddrW-1:0]  m_addr_q, m_addr_d;

  logic [HW-1:0]     mem_q [POOL_UNITS];
  logic [HW-1:0]     rd_data_q;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [HW-1:0]     wr_data;

  logic [LW-1:0]     rd_link, rd_size;
  logic [ReqW-1:0]   in_req;
  logic [AddrW-1:0]  in_addr;
  logic [CW-1:0]     init_n, free_p, split_n, b_end;
  logic [SW-1:0]     steps_inc;

  assign rd_link = rd_data_q[HW-1:LW];
  assign rd_size = rd_data_q[LW-1:0];
  assign in_req  = s_axis_tdata[ReqW-1:0];
  assign in_addr = s_axis_tdata[ReqW+AddrW-1:ReqW];

  assign init_n    = (CW'(pool_q) > PoolC) ? PoolC : CW'(pool_q);
  assign free_p    = CW'(in_addr) - CW'(1);
  assign split_n   = CW'(p_q) + need_q;
  assign b_end     = CW'(b_q) + CW'(b_size_q);
  assign steps_inc = steps_q + SW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    steps_d      = steps_q;
    need_d       = need_q;
    p_d          = p_q;
    q_d          = q_q;
    b_d          = b_q;
    bh_d         = bh_q;
    b_size_d     = b_size_q;
    cur_link_d   = cur_link_q;
    cur_size_d   = cur_size_q;
    new_link_d   = new_link_q;
    split_d      = split_q;
    res_ok_d     = res_ok_q;
    res_addr_d   = res_addr_q;
    m_valid_d    = m_valid_q;
    m_granted_d  = m_granted_q;
    m_addr_d     = m_addr_q;
    rd_en        = 1'b0;
    rd_addr      = p_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = p_q[AW-1:0];
    wr_data      = {cur_link_q, cur_size_q};
    s_axis_tready = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          res_ok_d   = 1'b1;
          res_addr_d = '0;
          bh_d       = 1'b1;
          steps_d    = '0;
          state_d    = S_DONE;
          case (s_axis_tuser)
            MODE_INIT: begin
              if (init_n == '0) begin
                head_d = Nil;
              end else begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {Nil, init_n[LW-1:0]};
                head_d  = '0;
              end
            end
            MODE_ALLOC: begin
              need_d  = CW'((CW'(in_req) + CW'(UnitBytes - 1)) / UnitBytes) + CW'(1);
              p_d     = head_q;
              state_d = S_A_RD;
            end
            MODE_FREE: begin
              if (in_addr != '0 && free_p < PoolC) begin
                p_d     = free_p[LW-1:0];
                q_d     = head_q;
                state_d = S_F_CHK;
              end
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end

      S_A_RD: begin
        if (CW'(p_q) >= PoolC) begin
          res_ok_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = p_q[AW-1:0];
          state_d = S_A_EV;
        end
      end

      S_A_EV: begin
        cur_link_d = rd_link;
        cur_size_d = rd_size;
        if (CW'(rd_size) >= need_q) begin
          if (CW'(rd_size) == need_q) begin
            split_d    = 1'b0;
            new_link_d = rd_link;
          end else begin
            split_d    = 1'b1;
            new_link_d = (split_n >= PoolC) ? Nil : split_n[LW-1:0];
          end
          state_d = S_A_WN;
        end else begin
          bh_d     = 1'b0;
          b_d      = p_q[AW-1:0];
          b_size_d = rd_size;
          p_d      = rd_link;
          steps_d  = steps_inc;
          if (steps_inc > PoolS) begin
            res_ok_d = 1'b0;
            state_d  = S_DONE;
          end else begin
            state_d = S_A_RD;
          end
        end
      end

      S_A_WN: begin
        if (split_q && new_link_q != Nil) begin
          wr_en   = 1'b1;
          wr_addr = new_link_q[AW-1:0];
          wr_data = {cur_link_q, cur_size_q - need_q[LW-1:0]};
        end
        state_d = S_A_WB;
      end

      S_A_WB: begin
        if (bh_q) begin
          head_d = new_link_q;
        end else begin
          wr_en   = 1'b1;
          wr_addr = b_q;
          if (split_q && new_link_q == {1'b0, b_q}) begin
            wr_data = {new_link_q, cur_size_q - need_q[LW-1:0]};
          end else begin
            wr_data = {new_link_q, b_size_q};
          end
        end
        state_d = S_A_WP;
      end

      S_A_WP: begin
        wr_en      = 1'b1;
        wr_addr    = p_q[AW-1:0];
        wr_data    = {cur_link_q, need_q[LW-1:0]};
        res_ok_d   = 1'b1;
        res_addr_d = AddrW'(CW'(p_q) + CW'(1));
        state_d    = S_DONE;
      end

      S_F_CHK: begin
        if (CW'(q_q) < PoolC && q_q < p_q && steps_q <= PoolS) begin
          rd_en   = 1'b1;
          rd_addr = q_q[AW-1:0];
          state_d = S_F_EV;
        end else begin
          if (CW'(q_q) >= PoolC) begin
            q_d = Nil;
          end
          state_d = S_F_RDP;
        end
      end

      S_F_EV: begin
        bh_d     = 1'b0;
        b_d      = q_q[AW-1:0];
        b_size_d = rd_size;
        q_d      = rd_link;
        steps_d  = steps_inc;
        state_d  = S_F_CHK;
      end

      S_F_RDP: begin
        rd_en   = 1'b1;
        rd_addr = p_q[AW-1:0];
        state_d = S_F_EVP;
      end

      S_F_EVP: begin
        cur_size_d = rd_size;
        cur_link_d = q_q;
        if (q_q != Nil && CW'(q_q) == CW'(p_q) + CW'(rd_size)) begin
          state_d = S_F_RDQ;
        end else begin
          state_d = S_F_WP;
        end
      end

      S_F_RDQ: begin
        rd_en   = 1'b1;
        rd_addr = q_q[AW-1:0];
        state_d = S_F_EVQ;
      end

      S_F_EVQ: begin
        cur_size_d = cur_size_q + rd_size;
        cur_link_d = rd_link;
        state_d    = S_F_WP;
      end

      S_F_WP: begin
        wr_en   = 1'b1;
        wr_addr = p_q[AW-1:0];
        wr_data = {cur_link_q, cur_size_q};
        if (bh_q) begin
          head_d   = p_q;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          state_d = S_F_WB;
        end
      end

      S_F_WB: begin
        wr_en   = 1'b1;
        wr_addr = b_q;
        if (CW'(p_q) == b_end) begin
          wr_data = {cur_link_q, b_size_q + cur_size_q};
        end else begin
          wr_data = {p_q, b_size_q};
        end
        res_ok_d = 1'b1;
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d   = 1'b1;
          m_granted_d = res_ok_q;
          m_addr_d    = res_ok_q ? res_addr_q : '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= Nil;
      pool_q    <= CfgReset;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      steps_q   <= steps_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q      <= need_d;
    p_q         <= p_d;
    q_q         <= q_d;
    b_q         <= b_d;
    bh_q        <= bh_d;
    b_size_q    <= b_size_d;
    cur_link_q  <= cur_link_d;
    cur_size_q  <= cur_size_d;
    new_link_q  <= new_link_d;
    split_q     <= split_d;
    res_ok_q    <= res_ok_d;
    res_addr_q  <= res_addr_d;
    m_granted_q <= m_granted_d;
    m_addr_q    <= m_addr_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OutDataW - AddrW)'(0), m_addr_q};
  assign m_axis_tuser  = m_granted_q;

`ifndef ASSERT_OFF
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[AddrW-1:0] == '0)
    else $error("failed request carries an address");

  a_init_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_INIT |=> state_q == S_DONE)
    else $error("init did not finish in one cycle");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= PoolS + SW'(1))
    else $error("free list walk ran past its bound");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_coalescing_allocator_top: directed and random
// init, allocate and free requests against an in-bench free-list predictor.
// Depends on fca_pkg and the allocator RTL.

module testbench;
  import fca_pkg::*;

  localparam int PoolUnits = PoolUnitsDef;
  localparam int NilLink = PoolUnits;
  localparam int LiveCap = 48;
  localparam int PhaseItems = 225;
  localparam int DrainCycles = 200;
  localparam logic [ModeW-1:0] ModeNone = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ReqW-1:0]  req_bytes;
    logic [AddrW-1:0] block_addr;
  } request_t;

  typedef struct packed {
    logic             granted;
    logic [AddrW-1:0] addr;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [ModeW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  first_fit_coalescing_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic [CfgW-1:0] link_mem [PoolUnits];
  logic [CfgW-1:0] size_mem [PoolUnits];
  logic [CfgW-1:0] head_link = CfgW'(NilLink);
  logic [CfgW-1:0] pool_cfg = CfgReset;

  request_t request_q[$];
  grant_t grant_q[$];
  logic [AddrW-1:0] live_blocks[$];
  request_t held_req;
  int unsigned issued = 0;
  int unsigned accepted = 0;
  int unsigned mismatches = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(64'd100_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic void set_link(input bit at_head, input int b, input int v);
    if (at_head) head_link = CfgW'(v);
    else if (b < PoolUnits) link_mem[b] = CfgW'(v);
  endfunction

  function automatic grant_t predict_grant(input request_t rq);
    grant_t res;
    int need, p, b, q, n, steps;
    bit at_head;
    res = '0;
    at_head = 1'b1;
    b = 0;
    steps = 0;
    case (rq.mode)
      MODE_INIT: begin
        n = (pool_cfg > PoolUnits) ? PoolUnits : int'(pool_cfg);
        if (n == 0) begin
          head_link = CfgW'(NilLink);
        end else begin
          link_mem[0] = CfgW'(NilLink);
          size_mem[0] = CfgW'(n);
          head_link = '0;
        end
        live_blocks.delete();
        res.granted = 1'b1;
      end
      MODE_ALLOC: begin
        need = (int'(rq.req_bytes) + UnitBytes - 1) / UnitBytes + 1;
        p = head_link;
        while (p < PoolUnits && int'(size_mem[p]) < need && steps <= PoolUnits) begin
          at_head = 1'b0;
          b = p;
          p = link_mem[p];
          steps++;
        end
        if (p < PoolUnits && steps <= PoolUnits && int'(size_mem[p]) >= need) begin
          if (int'(size_mem[p]) == need) begin
            set_link(at_head, b, link_mem[p]);
          end else begin
            n = p + need;
            if (n < PoolUnits) begin
              link_mem[n] = link_mem[p];
              size_mem[n] = CfgW'(int'(size_mem[p]) - need);
              set_link(at_head, b, n);
            end else begin
              set_link(at_head, b, NilLink);
            end
          end
          size_mem[p] = CfgW'(need);
          res.granted = 1'b1;
          res.addr = AddrW'(p + 1);
          if (res.addr != 0) live_blocks.push_back(res.addr);
        end
      end
      MODE_FREE: begin
        p = int'(rq.block_addr) - 1;
        if (rq.block_addr != 0 && p < PoolUnits) begin
          q = head_link;
          while (q < PoolUnits && q < p && steps <= PoolUnits) begin
            at_head = 1'b0;
            b = q;
            q = link_mem[q];
            steps++;
          end
          if (q >= PoolUnits) q = NilLink;
          set_link(at_head, b, p);
          link_mem[p] = CfgW'(q);
          if (q != NilLink && q == p + int'(size_mem[p])) begin
            size_mem[p] = size_mem[p] + size_mem[q];
            link_mem[p] = link_mem[q];
          end
          if (!at_head && b < PoolUnits && p == b + int'(size_mem[b])) begin
            size_mem[b] = size_mem[b] + size_mem[p];
            link_mem[b] = link_mem[p];
          end
        end
        res.granted = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        grant_q.push_back(predict_grant(held_req));
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          held_req = request_q.pop_front();
          s_axis_tdata <= {{(InDataW - ReqW - AddrW){1'b0}}, held_req.block_addr,
                           held_req.req_bytes};
          s_axis_tuser <= held_req.mode;
          s_axis_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: granted %0d, result_addr %0d",
                 m_axis_tuser[0], m_axis_tdata[AddrW-1:0]);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          if (m_axis_tuser[0] !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata[AddrW-1:0] !== want.addr) begin
            $error("result_addr: expected %0d, actual %0d", want.addr,
                   m_axis_tdata[AddrW-1:0]);
            mismatches++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(3) == 0) recv_stall <= pick_gap();
      end
    end
  end

  task automatic send_request(input logic [ModeW-1:0] mode, input logic [ReqW-1:0] req,
                              input logic [AddrW-1:0] addr);
    request_t rq;
    rq.mode = mode;
    rq.req_bytes = req;
    rq.block_addr = addr;
    while (request_q.size() >= 4) @(negedge clk_i);
    request_q.push_back(rq);
    issued++;
  endtask

  task automatic wait_accepted();
    while (request_q.size() != 0 || accepted != issued) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    wait_accepted();
    while (grant_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_pool_units(input logic [CfgW-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    pool_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // free a block by address; live set must reflect every accepted request
  task automatic free_block(input logic [AddrW-1:0] addr);
    wait_accepted();
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    send_request(MODE_FREE, ReqW'($urandom), addr);
  endtask

  task automatic free_random_live();
    int idx;
    logic [AddrW-1:0] addr;
    wait_accepted();
    if (live_blocks.size() == 0) begin
      send_request(MODE_ALLOC, ReqW'($urandom_range(0, 64)), AddrW'($urandom));
    end else begin
      idx = $urandom_range(live_blocks.size() - 1);
      addr = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(MODE_FREE, ReqW'($urandom), addr);
    end
  endtask

  function automatic logic [ReqW-1:0] pick_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 5) return ReqW'($urandom);
    if (r < 70) return ReqW'($urandom_range(0, 64));
    return ReqW'($urandom_range(0, 2047));
  endfunction

  task automatic run_phase(input logic [CfgW-1:0] pool, input bit quiet, input bit hold);
    int r;
    set_pool_units(pool);
    calm = quiet;
    send_request(MODE_INIT, ReqW'($urandom), AddrW'($urandom));
    for (int k = 0; k < PhaseItems; k++) begin
      if (hold && k == PhaseItems / 2) wait_drained();
      r = $urandom_range(99);
      if (live_blocks.size() >= LiveCap) r = 50;
      if (r < 40) send_request(MODE_ALLOC, pick_bytes(), AddrW'($urandom));
      else if (r < 75) free_random_live();
      else if (r < 79) send_request(MODE_FREE, ReqW'($urandom), '0);
      else if (r < 83) send_request(ModeNone, ReqW'($urandom), AddrW'($urandom));
      else if (r < 85) send_request(MODE_INIT, ReqW'($urandom), AddrW'($urandom));
      else send_request(MODE_ALLOC, pick_bytes(), AddrW'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < PoolUnits; i++) begin
      link_mem[i] = '0;
      size_mem[i] = '0;
    end
    while (!rst_ni) @(negedge clk_i);

    // empty list before init, no-op mode, null free
    send_request(MODE_ALLOC, 15'd5, '0);
    send_request(ModeNone, '1, '1);
    send_request(MODE_FREE, '1, '0);
    // whole pool, tail unit grant wraps the address, then splits and merges
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 15'd32752, '0);
    send_request(MODE_ALLOC, 15'd0, '0);
    send_request(MODE_ALLOC, 15'd1, '0);
    free_block(12'd1);
    send_request(MODE_ALLOC, 15'd32767, '0);
    send_request(MODE_ALLOC, 15'd8, '0);
    send_request(MODE_ALLOC, 15'd9, '0);
    send_request(MODE_ALLOC, 15'd16, '0);
    free_block(12'd3);
    free_block(12'd1);
    free_block(12'd6);
    // zero pool, saturated pool, smallest pool
    set_pool_units('0);
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 15'd0, '0);
    set_pool_units('1);
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 15'd0, '0);
    set_pool_units(13'd2);
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 15'd8, '0);
    send_request(MODE_ALLOC, 15'd0, '0);

    run_phase(13'd4096, 1'b0, 1'b0);
    run_phase(CfgW'($urandom_range(2, 16)), 1'b0, 1'b1);
    run_phase('1, 1'b0, 1'b0);
    run_phase(CfgW'($urandom_range(17, 200)), 1'b1, 1'b0);
    run_phase(13'd2, 1'b0, 1'b0);
    run_phase(CfgW'($urandom), 1'b0, 1'b0);
    run_phase(CfgW'($urandom_range(64, 1024)), 1'b0, 1'b0);
    run_phase(13'd4096, 1'b0, 1'b0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
